>>> rtl/sfp_pkg.sv
// Shared types and constants for the start-of-frame / length frame parser.
// Used by sfp_ctrl, sfp_datapath and the top level; no dependencies.
package sfp_pkg;

  localparam int BufferDepth = 64;
  localparam int AddrW       = $clog2(BufferDepth);
  localparam int FillW       = $clog2(BufferDepth + 1);
  localparam int CountW      = 6;

  localparam logic [7:0] StartByteReset      = 8'd226;
  localparam logic [7:0] LengthOverheadReset = 8'd4;
  localparam logic [5:0] MaxPayloadReset     = 6'd53;

  localparam logic [1:0] CfgStartByte      = 2'd0;
  localparam logic [1:0] CfgLengthOverhead = 2'd1;
  localparam logic [1:0] CfgMaxPayload     = 2'd2;

  typedef enum logic [3:0] {
    S_HUNT,
    S_VER,
    S_CTL,
    S_LEN,
    S_SN,
    S_CMD,
    S_STA,
    S_PAY,
    S_CRC,
    S_EOF,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic store;
    logic restart;
    logic clear;
    logic cnt_clr;
    logic cnt_inc;
    logic ctl_load;
    logic len_load;
    logic drain;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic cnt_one;
    logic cnt_hit_len;
    logic len_short;
    logic len_long;
    logic pay_zero;
    logic full;
    logic drain_done;
  } status_t;

endpackage

>>> rtl/sfp_datapath.sv
// Datapath of the frame parser: configuration registers, counters, frame store
// and the output register. Driven by commands from sfp_ctrl; uses sfp_pkg.
module sfp_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic [7:0]             rx_byte,
  input  sfp_pkg::cmd_t          cmd,
  output sfp_pkg::status_t       status,
  output logic                   frame_valid,
  input  logic                   frame_ready,
  output logic [7:0]             frame_byte,
  output logic                   last_byte,
  output logic [3:0]             frame_seq,
  output logic [1:0]             frame_type,
  output logic [1:0]             frame_reserved
);

  logic [7:0] start_byte;
  logic [7:0] length_overhead;
  logic [5:0] max_payload;

  logic [sfp_pkg::CountW-1:0] phase_count;
  logic [sfp_pkg::CountW-1:0] phase_count_inc;
  logic [5:0]                 payload_length;
  logic [7:0]                 len_diff;
  logic [sfp_pkg::FillW-1:0]  fill_level;
  logic [sfp_pkg::FillW-1:0]  rd_ptr;
  logic [sfp_pkg::AddrW-1:0]  wr_addr;
  logic [3:0]                 seq_field;
  logic [1:0]                 type_field;
  logic [1:0]                 reserved_field;
  logic                       load;

  logic [7:0] frame_store [sfp_pkg::BufferDepth];

  assign phase_count_inc = phase_count + sfp_pkg::CountW'(1);
  assign len_diff        = rx_byte - length_overhead;
  assign wr_addr         = cmd.restart ? '0 : fill_level[sfp_pkg::AddrW-1:0];
  assign load            = cmd.drain && (rd_ptr != fill_level) &&
                           (!frame_valid || frame_ready);

  always_comb begin
    status.is_start    = (rx_byte == start_byte);
    status.cnt_one     = (phase_count == sfp_pkg::CountW'(1));
    status.cnt_hit_len = (phase_count_inc == payload_length);
    status.len_short   = (rx_byte < length_overhead);
    status.len_long    = (len_diff > {2'b00, max_payload});
    status.pay_zero    = (payload_length == 6'd0);
    status.full        = (fill_level == sfp_pkg::FillW'(sfp_pkg::BufferDepth));
    status.drain_done  = (rd_ptr == fill_level);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte      <= sfp_pkg::StartByteReset;
      length_overhead <= sfp_pkg::LengthOverheadReset;
      max_payload     <= sfp_pkg::MaxPayloadReset;
    end else if (cfg_we) begin
      case (cfg_index)
        sfp_pkg::CfgStartByte:      start_byte      <= cfg_data;
        sfp_pkg::CfgLengthOverhead: length_overhead <= cfg_data;
        sfp_pkg::CfgMaxPayload:     max_payload     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count    <= '0;
      payload_length <= '0;
      fill_level     <= '0;
      rd_ptr         <= '0;
      seq_field      <= '0;
      type_field     <= '0;
      reserved_field <= '0;
      frame_valid    <= 1'b0;
    end else begin
      if (cmd.ctl_load) begin
        seq_field      <= rx_byte[7:4];
        type_field     <= rx_byte[3:2];
        reserved_field <= rx_byte[1:0];
      end
      if (cmd.clear) begin
        phase_count    <= '0;
        payload_length <= '0;
        fill_level     <= '0;
        rd_ptr         <= '0;
      end else begin
        if (cmd.cnt_clr) begin
          phase_count <= '0;
        end else if (cmd.cnt_inc) begin
          phase_count <= phase_count_inc;
        end
        if (cmd.len_load) begin
          payload_length <= len_diff[5:0];
        end
        if (cmd.store) begin
          fill_level <= cmd.restart ? sfp_pkg::FillW'(1)
                                    : fill_level + sfp_pkg::FillW'(1);
        end
        if (load) begin
          rd_ptr <= rd_ptr + sfp_pkg::FillW'(1);
        end
      end
      if (load) begin
        frame_valid <= 1'b1;
      end else if (frame_ready) begin
        frame_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      frame_store[wr_addr] <= rx_byte;
    end
    if (load) begin
      frame_byte     <= frame_store[rd_ptr[sfp_pkg::AddrW-1:0]];
      last_byte      <= (rd_ptr + sfp_pkg::FillW'(1) == fill_level);
      frame_seq      <= seq_field;
      frame_type     <= type_field;
      frame_reserved <= reserved_field;
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= sfp_pkg::FillW'(sfp_pkg::BufferDepth))
    else $error("fill level beyond store depth");
  a_rd_bound: assert property (@(posedge clk) disable iff (rst)
    rd_ptr <= fill_level)
    else $error("read pointer passed fill level");
  a_store_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.store |=> fill_level != '0)
    else $error("store left fill level at zero");
  a_no_store_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.drain |-> !cmd.store)
    else $error("store during drain");
`endif

endmodule

>>> rtl/sfp_ctrl.sv
// Controller of the frame parser: tracks the frame phase and issues
// datapath commands from datapath status. Uses sfp_pkg.
module sfp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_ready,
  input  sfp_pkg::status_t  status,
  output sfp_pkg::cmd_t     cmd
);

  sfp_pkg::state_t state;
  sfp_pkg::state_t state_next;
  sfp_pkg::state_t phase_next;
  logic            accept;
  logic            len_abort;
  logic            ver_restart;
  logic            full_abort;

  assign rx_ready    = (state != sfp_pkg::S_DRAIN);
  assign accept      = rx_valid && rx_ready;
  assign len_abort   = (state == sfp_pkg::S_LEN) && (status.len_short || status.len_long);
  assign ver_restart = (state == sfp_pkg::S_VER) && status.is_start;
  assign full_abort  = status.full && (state != sfp_pkg::S_HUNT) && !ver_restart && !len_abort;

  always_comb begin
    phase_next = state;
    case (state)
      sfp_pkg::S_HUNT: if (status.is_start) phase_next = sfp_pkg::S_VER;
      sfp_pkg::S_VER: begin
        if (!status.is_start && status.cnt_one) phase_next = sfp_pkg::S_CTL;
      end
      sfp_pkg::S_CTL: phase_next = sfp_pkg::S_LEN;
      sfp_pkg::S_LEN: phase_next = len_abort ? sfp_pkg::S_HUNT : sfp_pkg::S_SN;
      sfp_pkg::S_SN:  if (status.cnt_one) phase_next = sfp_pkg::S_CMD;
      sfp_pkg::S_CMD: phase_next = sfp_pkg::S_STA;
      sfp_pkg::S_STA: phase_next = status.pay_zero ? sfp_pkg::S_CRC : sfp_pkg::S_PAY;
      sfp_pkg::S_PAY: if (status.cnt_hit_len) phase_next = sfp_pkg::S_CRC;
      sfp_pkg::S_CRC: if (status.cnt_one) phase_next = sfp_pkg::S_EOF;
      sfp_pkg::S_EOF: phase_next = sfp_pkg::S_DRAIN;
      default:        phase_next = sfp_pkg::S_HUNT;
    endcase
  end

  always_comb begin
    state_next = state;
    if (state == sfp_pkg::S_DRAIN) begin
      if (status.drain_done) state_next = sfp_pkg::S_HUNT;
    end else if (accept) begin
      state_next = full_abort ? sfp_pkg::S_HUNT : phase_next;
    end
  end

  always_comb begin
    cmd = '0;
    if (state == sfp_pkg::S_DRAIN) begin
      cmd.drain = !status.drain_done;
      cmd.clear = status.drain_done;
    end else if (accept) begin
      cmd.ctl_load = (state == sfp_pkg::S_CTL);
      cmd.restart  = ver_restart;
      cmd.clear    = len_abort || full_abort;
      cmd.store    = !len_abort && !full_abort &&
                     ((state != sfp_pkg::S_HUNT) || status.is_start);
      cmd.len_load = (state == sfp_pkg::S_LEN) && !len_abort;
      case (state)
        sfp_pkg::S_HUNT: cmd.cnt_clr = status.is_start;
        sfp_pkg::S_VER: begin
          cmd.cnt_clr = status.is_start || status.cnt_one;
          cmd.cnt_inc = !status.is_start;
        end
        sfp_pkg::S_LEN: cmd.cnt_clr = 1'b1;
        sfp_pkg::S_SN:  cmd.cnt_inc = 1'b1;
        sfp_pkg::S_STA: cmd.cnt_clr = 1'b1;
        sfp_pkg::S_PAY: begin
          cmd.cnt_clr = status.cnt_hit_len;
          cmd.cnt_inc = 1'b1;
        end
        sfp_pkg::S_CRC: cmd.cnt_inc = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfp_pkg::S_HUNT;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_drain_from_eof: assert property (@(posedge clk) disable iff (rst)
    $rose(state == sfp_pkg::S_DRAIN) |-> $past(state) == sfp_pkg::S_EOF)
    else $error("drain entered from a phase other than end byte");
  a_clear_no_store: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !cmd.store)
    else $error("clear and store issued together");
  a_restart_store: assert property (@(posedge clk) disable iff (rst)
    cmd.restart |-> cmd.store && cmd.cnt_clr)
    else $error("restart without store and count clear");
`endif

endmodule

>>> rtl/sof_length_frame_parser.sv
// Start-of-frame / length-delimited frame parser, top level.
// Receive channel rx_valid/rx_ready/rx_byte takes one link byte per transaction.
// Bytes are dropped while hunting for the start byte; a frame (start, version,
// control, length, sequence, command, status, payload, CRC, end) is buffered
// in a 64-byte store and then sent on the frame channel frame_valid/frame_ready,
// one byte per transaction, last_byte marking the final byte, with frame_seq,
// frame_type and frame_reserved taken from the control byte. While parsing,
// rx_ready is high and a byte is taken every cycle that rx_valid is high. Once
// the end byte is taken, the drain state is entered and the output register
// loads the first byte from the store. rx_ready is low during the drain; the
// store read port sets the one-byte-per-cycle drain rate while frame_ready is
// high. A stalled receiver holds the output register and the drain; the final
// byte may still wait while new bytes arrive. Short length, payload over
// max_payload or store overflow drop the frame. Configuration (cfg_we,
// cfg_index, cfg_data) must be written by the user only while idle; the block
// does not enforce this. Reset (rst, synchronous) returns to hunting, empties
// the store and restores start_byte 226, length_overhead 4 and max_payload 53.
module sof_length_frame_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       frame_valid,
  input  logic       frame_ready,
  output logic [7:0] frame_byte,
  output logic       last_byte,
  output logic [3:0] frame_seq,
  output logic [1:0] frame_type,
  output logic [1:0] frame_reserved
);

  sfp_pkg::cmd_t    cmd;
  sfp_pkg::status_t status;

  sfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sfp_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .status         (status),
    .frame_valid    (frame_valid),
    .frame_ready    (frame_ready),
    .frame_byte     (frame_byte),
    .last_byte      (last_byte),
    .frame_seq      (frame_seq),
    .frame_type     (frame_type),
    .frame_reserved (frame_reserved)
  );

endmodule
